// ===== sv/tbrl_pkg.sv =====
// Shared types and constants for the token bucket rate limiter.
package tbrl_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned CNT_W  = $clog2(WORD_W);

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam t_word NS_PER_SEC = t_word'(64'd1000000000);
    localparam t_cnt  STEP_LAST  = t_cnt'(WORD_W - 1);

    localparam logic [1:0] CFG_BURST = 2'd0;
    localparam logic [1:0] CFG_RATE  = 2'd1;

endpackage

// ===== sv/token_bucket_rate_limiter.sv =====
// Token bucket rate limiter with debt: bit-serial multiply and divide datapath.
// Restart, zero request or zero rate: the word goes straight to ST_DONE, which registers the result to the output.
// Request: up to four 64-step passes over the shared r_acc/r_lo/r_mc registers, using
// shift-add multiply and restoring-divide steps (rate*elapsed, /1e9, debt*1e9, /rate).
// One word in flight; a new word is taken while the previous result waits.
// Synchronous active-low reset clears config, balance and refill time to zero.
module token_bucket_rate_limiter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [63:0]   i_cfg_data,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,  // now_ns [63:0], request_tokens [127:64]
    input  logic          i_s_axis_tuser,  // op [0]
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [63:0]   o_m_axis_tdata,  // delay_ns [63:0]
    output logic          o_m_axis_tuser   // in_debt [0]
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL1 = 4'd1;
    localparam logic [3:0] ST_CHK1 = 4'd2;
    localparam logic [3:0] ST_DIV1 = 4'd3;
    localparam logic [3:0] ST_REF  = 4'd4;
    localparam logic [3:0] ST_WD1  = 4'd5;
    localparam logic [3:0] ST_WD2  = 4'd6;
    localparam logic [3:0] ST_WD3  = 4'd7;
    localparam logic [3:0] ST_MUL2 = 4'd8;
    localparam logic [3:0] ST_CHK2 = 4'd9;
    localparam logic [3:0] ST_DIV2 = 4'd10;
    localparam logic [3:0] ST_DONE = 4'd11;

    logic [3:0]       r_state, n_state;
    tbrl_pkg::t_word  r_burst, n_burst;
    tbrl_pkg::t_word  r_rate, n_rate;
    tbrl_pkg::t_word  r_bal, n_bal;
    tbrl_pkg::t_word  r_last, n_last;
    tbrl_pkg::t_word  r_req, n_req;
    tbrl_pkg::t_word  r_tmp, n_tmp;
    tbrl_pkg::t_word  r_acc, n_acc;
    tbrl_pkg::t_word  r_lo, n_lo;
    tbrl_pkg::t_word  r_mc, n_mc;
    tbrl_pkg::t_cnt   r_cnt, n_cnt;
    tbrl_pkg::t_word  r_res, n_res;
    logic             r_res_debt, n_res_debt;
    logic             r_out_valid, n_out_valid;
    tbrl_pkg::t_word  r_out_data, n_out_data;
    logic             r_out_user, n_out_user;

    tbrl_pkg::t_word  in_now, in_req;
    logic [64:0]      mul_sum;
    tbrl_pkg::t_word  mul_acc, mul_lo;
    tbrl_pkg::t_word  div_sh, div_acc, div_lo;
    logic             div_ge;
    logic             accept;

    assign in_now = i_s_axis_tdata[63:0];
    assign in_req = i_s_axis_tdata[127:64];
    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    // shift-add multiply step: multiplier in r_lo, product low bits enter at the top
    always_comb begin
        mul_sum = {1'b0, r_acc} + (r_lo[0] ? {1'b0, r_mc} : 65'd0);
        mul_acc = mul_sum[64:1];
        mul_lo  = {mul_sum[0], r_lo[63:1]};
    end

    // restoring divide step: remainder in r_acc, dividend/quotient in r_lo
    always_comb begin
        div_sh  = {r_acc[62:0], r_lo[63]};
        div_ge  = r_acc[63] || (div_sh >= r_mc);
        div_acc = div_ge ? (div_sh - r_mc) : div_sh;
        div_lo  = {r_lo[62:0], div_ge};
    end

    always_comb begin
        n_state     = r_state;
        n_burst     = r_burst;
        n_rate      = r_rate;
        n_bal       = r_bal;
        n_last      = r_last;
        n_req       = r_req;
        n_tmp       = r_tmp;
        n_acc       = r_acc;
        n_lo        = r_lo;
        n_mc        = r_mc;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_res_debt  = r_res_debt;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                tbrl_pkg::CFG_BURST: n_burst = i_cfg_data;
                tbrl_pkg::CFG_RATE:  n_rate  = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_res      = '0;
                    n_res_debt = 1'b0;
                    n_req      = in_req;
                    if (i_s_axis_tuser) begin
                        n_bal   = r_burst;
                        n_last  = in_now;
                        n_state = ST_DONE;
                    end else if (in_req == '0 || r_rate == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_last = in_now;
                        if (r_last > in_now) begin
                            n_state = ST_WD1;
                        end else begin
                            n_acc   = '0;
                            n_lo    = in_now - r_last;
                            n_mc    = r_rate;
                            n_cnt   = '0;
                            n_state = ST_MUL1;
                        end
                    end
                end
            end
            ST_MUL1, ST_MUL2: begin
                n_acc = mul_acc;
                n_lo  = mul_lo;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == tbrl_pkg::STEP_LAST) begin
                    n_state = (r_state == ST_MUL1) ? ST_CHK1 : ST_CHK2;
                end
            end
            ST_CHK1: begin
                n_tmp = r_burst - r_bal;
                if (r_acc != '0) begin
                    n_bal   = r_burst;
                    n_state = ST_WD1;
                end else begin
                    n_acc   = '0;
                    n_mc    = tbrl_pkg::NS_PER_SEC;
                    n_cnt   = '0;
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1, ST_DIV2: begin
                n_acc = div_acc;
                n_lo  = div_lo;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == tbrl_pkg::STEP_LAST) begin
                    n_state = (r_state == ST_DIV1) ? ST_REF : ST_DONE;
                    if (r_state == ST_DIV2) begin
                        n_res      = div_lo;
                        n_res_debt = 1'b1;
                    end
                end
            end
            ST_REF: begin
                n_bal   = (r_lo > r_tmp) ? r_burst : (r_bal + r_lo);
                n_state = ST_WD1;
            end
            ST_WD1: begin
                n_tmp   = r_bal - r_burst - 64'd1;
                n_state = ST_WD2;
            end
            ST_WD2: begin
                // clamp so debt never wraps into credit
                n_bal   = (r_req > r_tmp) ? (r_bal - r_tmp) : (r_bal - r_req);
                n_state = ST_WD3;
            end
            ST_WD3: begin
                if (r_bal > r_burst) begin
                    n_acc   = '0;
                    n_lo    = tbrl_pkg::NS_PER_SEC;
                    n_mc    = '0 - r_bal;
                    n_cnt   = '0;
                    n_state = ST_MUL2;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_CHK2: begin
                if (r_acc >= r_rate) begin
                    n_res      = '1;
                    n_res_debt = 1'b1;
                    n_state    = ST_DONE;
                end else begin
                    n_mc    = r_rate;
                    n_cnt   = '0;
                    n_state = ST_DIV2;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_out_user  = r_res_debt;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_burst     <= '0;
            r_rate      <= '0;
            r_bal       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_burst     <= n_burst;
            r_rate      <= n_rate;
            r_bal       <= n_bal;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_tmp      <= n_tmp;
        r_acc      <= n_acc;
        r_lo       <= n_lo;
        r_mc       <= n_mc;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_res_debt <= n_res_debt;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
